>>> rtl/qselu_pkg.sv
`default_nettype none

package qselu_pkg;

   localparam int CODE_W     = 8;
   localparam int SCALE_W    = 32;
   localparam int GAIN_W     = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_ZERO   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_ZERO  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_SCALE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_RECIP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_GAIN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LAMBDA_GAIN  = 3'd5;

   localparam logic [CODE_W-1:0]  RST_INPUT_ZERO   = 8'd0;
   localparam logic [CODE_W-1:0]  RST_OUTPUT_ZERO  = 8'd0;
   localparam logic [SCALE_W-1:0] RST_INPUT_SCALE  = 32'd16777216;
   localparam logic [SCALE_W-1:0] RST_OUTPUT_RECIP = 32'd65536;
   localparam logic [GAIN_W-1:0]  RST_ALPHA_GAIN   = 20'd109663;
   localparam logic [GAIN_W-1:0]  RST_LAMBDA_GAIN  = 20'd68858;

   // fixed-point constants
   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [29:0] LN2_Q30   = 30'd744261118;
   localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

   // Horner series for exp(-v), one step per term, n = 8 down to 1
   localparam int HORNER_STEPS = 8;
   localparam int RECIP_SHIFT  = 33;

   // ceil(2^33 / n) for n = 8 .. 1; exact quotient for any numerator below 2^30
   localparam logic [33:0] HORNER_RECIP [HORNER_STEPS] = '{
      34'd1073741824,   // n = 8
      34'd1227133514,   // n = 7
      34'd1431655766,   // n = 6
      34'd1717986919,   // n = 5
      34'd2147483648,   // n = 4
      34'd2863311531,   // n = 3
      34'd4294967296,   // n = 2
      34'd8589934592    // n = 1
   };

   // per-word sideband that rides along the pipe
   typedef struct packed {
      logic        neg;
      logic [30:0] xpos;
      logic [7:0]  k;
      logic [29:0] v;
   } side_type;

endpackage

`default_nettype wire

>>> rtl/quantized_selu_activation_core.sv
// Quantized SELU activation, one uint8 code per word.
// Input channel req_*: req_valid / req_stall with payload req_in_code. A word is
// taken at a rising edge with req_valid high and req_stall low.
// Result channel rsp_*: rsp_valid / rsp_stall with rsp_out_code and rsp_clipped,
// one result word per input word, in order.
// Configuration csr_*: csr_write, csr_index, csr_wdata; a write lands at the edge
// where csr_write is high. Unknown indexes are ignored. Write only while idle.
// Throughput: one word per cycle while rsp_stall does not hold the pipe. The
// datapath is 38 register stages plus the output register.
// The length comes from the exp series: eight Horner steps of three
// stages each (multiply, round, reciprocal divide).
// Stall: the whole pipe advances only while the output register is empty or
// being taken, so req_stall follows rsp_stall in the same cycle; nothing is
// dropped or repeated.
// Reset (synchronous, active high) empties the pipe and loads the default
// zero points, scales and gains.
`default_nettype none

module quantized_selu_activation_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [qselu_pkg::CODE_W-1:0]      req_in_code,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [qselu_pkg::CODE_W-1:0]      rsp_out_code,
   output logic                              rsp_clipped,
   input  logic                              csr_write,
   input  logic [qselu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [qselu_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import qselu_pkg::*;

   localparam int ST_D   = 1;
   localparam int ST_X   = 2;
   localparam int ST_SAT = 3;
   localparam int ST_TP  = 4;
   localparam int ST_TQ  = 5;
   localparam int ST_VP  = 6;
   localparam int ST_V   = 7;
   localparam int ST_H0  = 8;
   localparam int ST_AF  = ST_H0 + 3 * HORNER_STEPS;
   localparam int ST_EM  = ST_AF + 1;
   localparam int ST_M1  = ST_EM + 1;
   localparam int ST_Y   = ST_M1 + 1;
   localparam int ST_Z1  = ST_Y + 1;
   localparam int ST_Z   = ST_Z1 + 1;
   localparam int ST_W   = ST_Z + 1;

   // configuration registers
   logic [CODE_W-1:0]  input_zero_ff;
   logic [CODE_W-1:0]  output_zero_ff;
   logic [SCALE_W-1:0] input_scale_ff;
   logic [SCALE_W-1:0] output_recip_ff;
   logic [GAIN_W-1:0]  alpha_gain_ff;
   logic [GAIN_W-1:0]  lambda_gain_ff;
   logic [2*GAIN_W-1:0] al_ff;

   // flow control
   logic              adv;
   logic [ST_W:ST_D]  vld_ff;
   logic [ST_W:ST_D]  vld_in;
   logic              rsp_valid_ff;

   side_type side_ff [ST_SAT:ST_Z];
   side_type side_in [ST_SAT:ST_Z];

   // datapath
   logic signed [8:0]  d_ff,  d_in;
   logic signed [41:0] xf_ff, xf_in;
   logic [31:0]        m_ff,  m_in;
   logic [31:0]        xsat;
   logic               x_over, x_under;
   logic [62:0]        tp_ff, tp_in;
   logic [62:0]        tq_sum;
   logic [23:0]        r_ff,  r_in;
   logic [53:0]        vp_ff, vp_in;
   logic [53:0]        v_sum;

   logic [60:0] hp_ff [HORNER_STEPS];
   logic [60:0] hp_in [HORNER_STEPS];
   logic [29:0] hr_ff [HORNER_STEPS];
   logic [29:0] hr_in [HORNER_STEPS];
   logic [63:0] hq_ff [HORNER_STEPS];
   logic [63:0] hq_in [HORNER_STEPS];
   logic [30:0] h_a   [HORNER_STEPS];
   logic [60:0] h_rnd [HORNER_STEPS];

   logic [30:0] af_ff,  af_in;
   logic [16:0] em1_ff, em1_in;
   logic [5:0]  e_shamt;
   logic [30:0] e_sh;
   logic [18:0] e_inc;
   logic [16:0] e16;
   logic [36:0] pl_ff, pl_in;
   logic [36:0] ph_ff, ph_in;
   logic [50:0] pp_ff, pp_in;
   logic [60:0] yn_sum;
   logic [50:0] yp_sum;
   logic [34:0] ymag_ff, ymag_in;
   logic [50:0] zh_ff, zh_in;
   logic [47:0] zl_ff, zl_in;
   logic [47:0] zl_rnd;
   logic [51:0] zmag_ff, zmag_in;
   logic [51:0] oz24;
   logic        wneg_ff, wneg_in;
   logic [52:0] wmag_ff, wmag_in;
   logic [52:0] q_rnd;
   logic [28:0] qm;

   logic [CODE_W-1:0] rsp_out_code_ff, rsp_out_code_in;
   logic              rsp_clipped_ff,  rsp_clipped_in;

   // configuration write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         input_zero_ff   <= RST_INPUT_ZERO;
         output_zero_ff  <= RST_OUTPUT_ZERO;
         input_scale_ff  <= RST_INPUT_SCALE;
         output_recip_ff <= RST_OUTPUT_RECIP;
         alpha_gain_ff   <= RST_ALPHA_GAIN;
         lambda_gain_ff  <= RST_LAMBDA_GAIN;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_INPUT_ZERO:   input_zero_ff   <= csr_wdata[CODE_W-1:0];
            CSR_OUTPUT_ZERO:  output_zero_ff  <= csr_wdata[CODE_W-1:0];
            CSR_INPUT_SCALE:  input_scale_ff  <= csr_wdata[SCALE_W-1:0];
            CSR_OUTPUT_RECIP: output_recip_ff <= csr_wdata[SCALE_W-1:0];
            CSR_ALPHA_GAIN:   alpha_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_LAMBDA_GAIN:  lambda_gain_ff  <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // alpha*lambda, settles long before a word reaches the negative branch
   always_ff @(posedge clock) begin
      al_ff <= (2*GAIN_W)'(alpha_gain_ff) * (2*GAIN_W)'(lambda_gain_ff);
   end

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign vld_in    = {vld_ff[ST_W-1:ST_D], req_valid};

   // front: dequantize, saturate, range-reduce
   always_comb begin
      d_in   = $signed({1'b0, req_in_code}) - $signed({1'b0, input_zero_ff});
      xf_in  = 42'(d_ff) * 42'($signed({1'b0, input_scale_ff}));

      x_over  = !xf_ff[41] && (|xf_ff[40:31]);
      x_under = xf_ff[41] && !(&xf_ff[40:31]);
      if (x_over) begin
         xsat = 32'h7FFF_FFFF;
      end else if (x_under) begin
         xsat = 32'h8000_0000;
      end else begin
         xsat = xf_ff[31:0];
      end
      m_in   = xf_ff[41] ? (~xsat + 32'd1) : xsat;

      tp_in  = 63'(m_ff) * 63'(LOG2E_Q30);
      tq_sum = tp_ff + (63'(1) << 29);
      r_in   = tq_sum[53:30];
      vp_in  = 54'(r_ff) * 54'(LN2_Q30);
      v_sum  = vp_ff + (54'(1) << 23);
   end

   // sideband line
   always_comb begin
      side_in[ST_SAT].neg  = xf_ff[41];
      side_in[ST_SAT].xpos = xsat[30:0];
      side_in[ST_SAT].k    = '0;
      side_in[ST_SAT].v    = '0;
      for (int i = ST_SAT + 1; i <= ST_Z; i++) begin
         side_in[i] = side_ff[i-1];
      end
      side_in[ST_TQ].k = tq_sum[61:54];
      side_in[ST_V].v  = v_sum[53:24];
   end

   // Horner: a = 1 - round(v*a)/n
   always_comb begin
      for (int j = 0; j < HORNER_STEPS; j++) begin
         if (j == 0) begin
            h_a[j] = ONE_Q30;
         end else begin
            h_a[j] = ONE_Q30 - {1'b0, hq_ff[j-1][62:RECIP_SHIFT]};
         end
         hp_in[j] = 61'(side_ff[ST_H0 + 3*j - 1].v) * 61'(h_a[j]);
         h_rnd[j] = hp_ff[j] + (61'(1) << 29);
         hr_in[j] = h_rnd[j][59:30];
         hq_in[j] = 64'(hr_ff[j]) * 64'(HORNER_RECIP[j]);
      end
   end

   // back: 2^-k shift, SELU branches, output scaling, rounding
   always_comb begin
      af_in = ONE_Q30 - {1'b0, hq_ff[HORNER_STEPS-1][62:RECIP_SHIFT]};

      // rounded a >> (14 + k); anything at k >= 18 rounds to zero
      e_shamt = 6'd13 + 6'(side_ff[ST_AF].k[4:0]);
      e_sh    = af_ff >> e_shamt;
      e_inc   = {1'b0, e_sh[17:0]} + 19'd1;
      e16     = (side_ff[ST_AF].k >= 8'd18) ? 17'd0 : e_inc[17:1];
      em1_in  = 17'd65536 - e16;

      pl_in = 37'(em1_ff) * 37'(al_ff[GAIN_W-1:0]);
      ph_in = 37'(em1_ff) * 37'(al_ff[2*GAIN_W-1:GAIN_W]);
      pp_in = 51'(side_ff[ST_EM].xpos) * 51'(lambda_gain_ff);

      yn_sum = {ph_ff, 24'd0} + 61'({pl_ff, 4'd0}) + (61'(1) << 27);
      yp_sum = pp_ff + (51'(1) << 15);
      if (side_ff[ST_M1].neg) begin
         ymag_in = 35'(yn_sum[60:28]);
      end else begin
         ymag_in = yp_sum[50:16];
      end

      zh_in   = 51'(ymag_ff[34:16]) * 51'(output_recip_ff);
      zl_in   = 48'(ymag_ff[15:0]) * 48'(output_recip_ff);
      zl_rnd  = zl_ff + (48'(1) << 15);
      zmag_in = 52'(zh_ff) + 52'(zl_rnd[47:16]);

      oz24 = 52'({output_zero_ff, 24'd0});
      wneg_in = side_ff[ST_Z].neg && (zmag_ff > oz24);
      if (!side_ff[ST_Z].neg) begin
         wmag_in = 53'(zmag_ff) + 53'(oz24);
      end else if (wneg_in) begin
         wmag_in = 53'(zmag_ff - oz24);
      end else begin
         wmag_in = 53'(oz24 - zmag_ff);
      end

      // round half away from zero, then clamp
      q_rnd = wmag_ff + (53'(1) << 23);
      qm    = q_rnd[52:24];
      if (wneg_ff) begin
         rsp_out_code_in = '0;
         rsp_clipped_in  = (qm != 29'd0);
      end else if (|qm[28:8]) begin
         rsp_out_code_in = 8'd255;
         rsp_clipped_in  = 1'b1;
      end else begin
         rsp_out_code_in = qm[7:0];
         rsp_clipped_in  = 1'b0;
      end
   end

   // note: the ph term above is aligned by << 20 as {ph, 24'd0} with pl << 4,
   // i.e. the sum is scaled by 2^4 and the >> 24 becomes >> 28

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[ST_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff    <= d_in;
         xf_ff   <= xf_in;
         m_ff    <= m_in;
         tp_ff   <= tp_in;
         r_ff    <= r_in;
         vp_ff   <= vp_in;
         for (int i = ST_SAT; i <= ST_Z; i++) begin
            side_ff[i] <= side_in[i];
         end
         for (int j = 0; j < HORNER_STEPS; j++) begin
            hp_ff[j] <= hp_in[j];
            hr_ff[j] <= hr_in[j];
            hq_ff[j] <= hq_in[j];
         end
         af_ff   <= af_in;
         em1_ff  <= em1_in;
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
         pp_ff   <= pp_in;
         ymag_ff <= ymag_in;
         zh_ff   <= zh_in;
         zl_ff   <= zl_in;
         zmag_ff <= zmag_in;
         wneg_ff <= wneg_in;
         wmag_ff <= wmag_in;
         rsp_out_code_ff <= rsp_out_code_in;
         rsp_clipped_ff  <= rsp_clipped_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_code = rsp_out_code_ff;
   assign rsp_clipped  = rsp_clipped_ff;

endmodule

`default_nettype wire
